// File: sv/lz4_block_decoder_assert.svh
// Assertion macros used by the decoder RTL.
`ifndef LZ4_BLOCK_DECODER_ASSERT_SVH
`define LZ4_BLOCK_DECODER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define LZ4BD_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lz4 block decoder check failed");

// Next-cycle implication, off during reset.
`define LZ4BD_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lz4 block decoder check failed");

`endif

// File: sv/lz4bd_pkg.sv
package lz4bd_pkg;

  // block status codes
  localparam logic [1:0] ST_RUN       = 2'd0;
  localparam logic [1:0] ST_INPUT_END = 2'd1;
  localparam logic [1:0] ST_ZERO_OFF  = 2'd2;

  // per-item command from the parser to the history/output stage
  typedef struct packed {
    logic       emit;         // word carries a decompressed byte
    logic       from_hist;    // byte comes from the history read
    logic [7:0] lit_byte;     // literal byte
    logic       copy_pending;
    logic [1:0] status;
  } cmd_t;

endpackage

// File: sv/lz4bd_parser.sv
module lz4bd_parser #(
  parameter int WINDOW_BYTES = 65536,
  parameter int LENGTH_BITS  = 24,
  localparam int AW = $clog2(WINDOW_BYTES)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            req_type,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output lz4bd_pkg::cmd_t cmd,
  output logic [AW-1:0]   rd_addr,
  output logic [AW-1:0]   wr_addr
);

  localparam logic [2:0] PH_TOKEN  = 3'd0;
  localparam logic [2:0] PH_LITEXT = 3'd1;
  localparam logic [2:0] PH_LIT    = 3'd2;
  localparam logic [2:0] PH_OFFLO  = 3'd3;
  localparam logic [2:0] PH_OFFHI  = 3'd4;
  localparam logic [2:0] PH_MATEXT = 3'd5;
  localparam logic [2:0] PH_COPY   = 3'd6;
  localparam logic [2:0] PH_DRAIN  = 3'd7;

  localparam logic [3:0]             NIB_EXT   = 4'd15;
  localparam logic [7:0]             BYTE_MORE = 8'd255;
  localparam logic [LENGTH_BITS-1:0] MIN_MATCH = LENGTH_BITS'(4);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX   = {LENGTH_BITS{1'b1}};

  logic [AW-1:0]          wp, wp_next;
  logic [2:0]             phase, phase_next;
  logic [LENGTH_BITS-1:0] lit_rem, lit_rem_next;
  logic [LENGTH_BITS-1:0] mat_rem, mat_rem_next;
  logic [7:0]             off_lo, off_lo_next;
  logic [AW-1:0]          off, off_next;
  logic [3:0]             nib, nib_next;
  logic [1:0]             end_code, end_code_next;

  logic                   ended;
  logic                   copying;
  logic [AW-1:0]          wp_inc;
  logic [AW:0]            addr_diff;
  logic [15:0]            off_full;

  // offset modulo window: conditional subtracts, at most seven steps
  function automatic logic [AW-1:0] wrap_off(input logic [15:0] v);
    logic [23:0] r;
    r = {8'd0, v};
    for (int k = 6; k >= 0; k--) begin
      if (r >= (24'(WINDOW_BYTES) << k)) begin
        r = r - (24'(WINDOW_BYTES) << k);
      end
    end
    return r[AW-1:0];
  endfunction

  function automatic logic [LENGTH_BITS-1:0] sat_add(input logic [LENGTH_BITS-1:0] a,
                                                     input logic [7:0] b);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, a} + (LENGTH_BITS+1)'(b);
    return s[LENGTH_BITS] ? LEN_MAX : s[LENGTH_BITS-1:0];
  endfunction

  assign ended    = (end_code != lz4bd_pkg::ST_RUN);
  assign copying  = (phase == PH_COPY) || (phase == PH_DRAIN);
  assign wp_inc   = (wp == AW'(WINDOW_BYTES - 1)) ? '0 : wp + AW'(1);
  assign off_full = {in_byte, off_lo};

  // copy source lies off bytes behind the write pointer, wrapped in the window
  assign addr_diff = {1'b0, wp} - {1'b0, off};
  assign rd_addr   = (wp >= off) ? addr_diff[AW-1:0]
                                 : AW'(addr_diff + (AW+1)'(WINDOW_BYTES));
  assign wr_addr   = wp;

  always_comb begin
    wp_next       = wp;
    phase_next    = phase;
    lit_rem_next  = lit_rem;
    mat_rem_next  = mat_rem;
    off_lo_next   = off_lo;
    off_next      = off;
    nib_next      = nib;
    end_code_next = end_code;
    cmd           = '0;
    cmd.lit_byte  = in_byte;

    if (accept && !ended) begin
      if (req_type) begin
        if (copying && (mat_rem != '0)) begin
          cmd.emit      = 1'b1;
          cmd.from_hist = 1'b1;
          wp_next       = wp_inc;
          mat_rem_next  = mat_rem - LENGTH_BITS'(1);
          if (mat_rem == LENGTH_BITS'(1)) begin
            if (phase == PH_DRAIN) begin
              end_code_next = lz4bd_pkg::ST_INPUT_END;
            end else begin
              phase_next = PH_TOKEN;
            end
          end
        end
      end else begin
        case (phase)
          PH_TOKEN: begin
            lit_rem_next = LENGTH_BITS'(in_byte[7:4]);
            nib_next     = in_byte[3:0];
            if (in_last) begin
              end_code_next = lz4bd_pkg::ST_INPUT_END;
            end else if (in_byte[7:4] == NIB_EXT) begin
              phase_next = PH_LITEXT;
            end else if (in_byte[7:4] != 4'd0) begin
              phase_next = PH_LIT;
            end else begin
              phase_next = PH_OFFLO;
            end
          end
          PH_LITEXT: begin
            lit_rem_next = sat_add(lit_rem, in_byte);
            if (in_last) begin
              end_code_next = lz4bd_pkg::ST_INPUT_END;
            end else if (in_byte != BYTE_MORE) begin
              phase_next = PH_LIT;
            end
          end
          PH_LIT: begin
            cmd.emit = 1'b1;
            wp_next  = wp_inc;
            if (lit_rem != '0) begin
              lit_rem_next = lit_rem - LENGTH_BITS'(1);
            end
            if (in_last) begin
              end_code_next = lz4bd_pkg::ST_INPUT_END;
            end else if (lit_rem <= LENGTH_BITS'(1)) begin
              phase_next = PH_OFFLO;
            end
          end
          PH_OFFLO: begin
            off_lo_next = in_byte;
            if (in_last) begin
              end_code_next = lz4bd_pkg::ST_INPUT_END;
            end else begin
              phase_next = PH_OFFHI;
            end
          end
          PH_OFFHI: begin
            if (off_full == 16'd0) begin
              end_code_next = lz4bd_pkg::ST_ZERO_OFF;
            end else begin
              off_next     = wrap_off(off_full);
              mat_rem_next = LENGTH_BITS'(nib) + MIN_MATCH;
              if ((nib == NIB_EXT) && !in_last) begin
                phase_next = PH_MATEXT;
              end else begin
                phase_next = in_last ? PH_DRAIN : PH_COPY;
              end
            end
          end
          PH_MATEXT: begin
            mat_rem_next = sat_add(mat_rem, in_byte);
            if ((in_byte != BYTE_MORE) || in_last) begin
              phase_next = in_last ? PH_DRAIN : PH_COPY;
            end
          end
          default: begin
            // copy phases drop compressed bytes
          end
        endcase
      end
    end

    cmd.status       = end_code_next;
    cmd.copy_pending = (end_code_next == lz4bd_pkg::ST_RUN) &&
                       ((phase_next == PH_COPY) || (phase_next == PH_DRAIN)) &&
                       (mat_rem_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      phase    <= PH_TOKEN;
      lit_rem  <= '0;
      mat_rem  <= '0;
      off_lo   <= '0;
      off      <= '0;
      nib      <= '0;
      end_code <= lz4bd_pkg::ST_RUN;
    end else begin
      wp       <= wp_next;
      phase    <= phase_next;
      lit_rem  <= lit_rem_next;
      mat_rem  <= mat_rem_next;
      off_lo   <= off_lo_next;
      off      <= off_next;
      nib      <= nib_next;
      end_code <= end_code_next;
    end
  end

endmodule

// File: sv/lz4_block_decoder.sv
// LZ4 block decoder: takes one word per cycle on s_axis while ready, either
// a compressed byte (tuser 0) or a tick asking for one match byte (tuser 1),
// and returns exactly one word per accepted word on m_axis, through the
// stage-1 register and the output register. Sustained rate is one word per
// cycle while m_axis is ready: the parser updates its state in the accept
// cycle and issues the history read, the dual-port history memory (one read,
// one write per cycle) registers its answer, and a forwarding path covers a
// copy that reads the byte written in that same cycle (offset 1).
// Watch copy_pending to know when ticks are owed; status turns nonzero once
// the block has ended and then holds until reset.
`include "lz4_block_decoder_assert.svh"

module lz4_block_decoder #(
  parameter int WINDOW_BYTES = 65536,
  parameter int LENGTH_BITS  = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  input  logic        s_axis_tuser,  // [0] req_type
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] out_byte, [8] copy_pending, [10:9] status
  output logic        m_axis_tuser   // [0] out_valid
);

  localparam int AW = $clog2(WINDOW_BYTES);

  logic            accept;
  lz4bd_pkg::cmd_t cmd;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;

  logic [7:0]      hist [WINDOW_BYTES];
  logic [7:0]      hist_q;

  logic            s1_v;
  lz4bd_pkg::cmd_t s1_cmd;
  logic [AW-1:0]   s1_addr;
  logic            s1_adv;
  logic            s1_wr;
  logic [7:0]      s1_data;
  logic            fwd_hit;
  logic [7:0]      fwd_data;

  assign s1_adv        = s1_v && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_v || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  lz4bd_parser #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req_type (s_axis_tuser),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr)
  );

  // commit the stage-1 byte to history as it moves to the output
  assign s1_wr   = s1_adv && s1_cmd.emit;
  assign s1_data = !s1_cmd.from_hist ? s1_cmd.lit_byte :
                   fwd_hit           ? fwd_data : hist_q;

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      hist[s1_addr] <= s1_data;
    end
    if (accept) begin
      hist_q <= hist[rd_addr];
    end
  end

  // forward a byte written in the cycle of the read to the same entry
  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_hit  <= s1_wr && (s1_addr == rd_addr);
      fwd_data <= s1_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (accept) begin
      s1_v <= 1'b1;
    end else if (s1_adv) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd  <= cmd;
      s1_addr <= wr_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_axis_tuser <= s1_cmd.emit;
      m_axis_tdata <= {5'd0, s1_cmd.status, s1_cmd.copy_pending,
                       s1_cmd.emit ? s1_data : 8'd0};
    end
  end

  // once ended, later words carry the same status and no byte
  `LZ4BD_ASSERT_NOW(a_end_holds, clk, rst,
    accept && s1_v && (s1_cmd.status != lz4bd_pkg::ST_RUN),
    (cmd.status == s1_cmd.status) && !cmd.emit)
  // a held stage 1 must block the input side
  `LZ4BD_ASSERT_NOW(a_stall_blocks, clk, rst, s1_v && !s1_adv, !s_axis_tready)
  // an output word that raises tvalid comes from stage 1
  `LZ4BD_ASSERT_NOW(a_out_from_s1, clk, rst, $rose(m_axis_tvalid), $past(s1_v))

endmodule

// File: tb/sv/lz4_block_decoder_check.sv
module lz4_block_decoder_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  input  logic        s_axis_tuser,  // [0] req_type
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,  // [7:0] out_byte, [8] copy_pending, [10:9] status
  input  logic        m_axis_tuser,  // [0] out_valid
  output int          owed,
  output int          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    P_TOKEN, P_LIT_EXT, P_LIT, P_OFF_LO, P_OFF_HI, P_MATCH_EXT, P_COPY, P_DRAIN
  } parse_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       copy_pending;
    logic [1:0] status;
  } dec_word_t;

  logic [7:0]  hist_mem [0:65535];
  logic [15:0] wr_ptr;
  logic [15:0] offset;
  parse_t      phase;
  logic [23:0] lit_left;
  logic [23:0] match_left;
  logic [3:0]  match_nib;
  logic        ended;
  logic [1:0]  end_code;
  dec_word_t   decoded_q [$];

  function automatic logic [23:0] sat_len(input logic [23:0] a, input logic [7:0] b);
    logic [24:0] s;
    s = {1'b0, a} + 25'(b);
    return s[24] ? '1 : s[23:0];
  endfunction

  task automatic store_byte(input logic [7:0] b);
    hist_mem[wr_ptr] = b;
    wr_ptr++;
  endtask

  task automatic close_block(input logic [1:0] code);
    ended = 1'b1;
    end_code = code;
  endtask

  task automatic decode_word(input logic tick, input logic [7:0] b, input logic last,
                             output dec_word_t w);
    logic       ov;
    logic [7:0] ob;
    ov = 1'b0;
    ob = 8'h00;
    if (!ended) begin
      if (tick) begin
        if ((phase == P_COPY || phase == P_DRAIN) && match_left != 0) begin
          // offset wraps through the 16-bit window
          ob = hist_mem[wr_ptr - offset];
          ov = 1'b1;
          store_byte(ob);
          match_left--;
          if (match_left == 0) begin
            if (phase == P_DRAIN) close_block(lz4bd_pkg::ST_INPUT_END);
            else phase = P_TOKEN;
          end
        end
      end else begin
        case (phase)
          P_TOKEN: begin
            lit_left = {20'd0, b[7:4]};
            match_nib = b[3:0];
            if (last) close_block(lz4bd_pkg::ST_INPUT_END);
            else if (b[7:4] == 4'd15) phase = P_LIT_EXT;
            else if (b[7:4] != 4'd0) phase = P_LIT;
            else phase = P_OFF_LO;
          end
          P_LIT_EXT: begin
            lit_left = sat_len(lit_left, b);
            if (last) close_block(lz4bd_pkg::ST_INPUT_END);
            else if (b != 8'd255) phase = P_LIT;
          end
          P_LIT: begin
            ov = 1'b1;
            ob = b;
            store_byte(b);
            if (lit_left != 0) lit_left--;
            if (last) close_block(lz4bd_pkg::ST_INPUT_END);
            else if (lit_left == 0) phase = P_OFF_LO;
          end
          P_OFF_LO: begin
            offset = {8'h00, b};
            if (last) close_block(lz4bd_pkg::ST_INPUT_END);
            else phase = P_OFF_HI;
          end
          P_OFF_HI: begin
            offset[15:8] = b;
            if (offset == 16'd0) begin
              close_block(lz4bd_pkg::ST_ZERO_OFF);
            end else begin
              match_left = 24'(match_nib) + 24'd4;
              if (match_nib == 4'd15 && !last) phase = P_MATCH_EXT;
              else phase = last ? P_DRAIN : P_COPY;
            end
          end
          P_MATCH_EXT: begin
            match_left = sat_len(match_left, b);
            if (b != 8'd255 || last) phase = last ? P_DRAIN : P_COPY;
          end
          default: ;
        endcase
      end
    end
    w.emit = ov;
    w.data = ob;
    w.copy_pending = !ended && (phase == P_COPY || phase == P_DRAIN) && match_left != 0;
    w.status = ended ? end_code : lz4bd_pkg::ST_RUN;
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    dec_word_t w;
    dec_word_t want;
    if (rst) begin
      wr_ptr = '0;
      offset = '0;
      phase = P_TOKEN;
      lit_left = '0;
      match_left = '0;
      match_nib = '0;
      ended = 1'b0;
      end_code = lz4bd_pkg::ST_RUN;
      decoded_q.delete();
      owed <= 0;
    end else begin
      // predict first so a word output in the same cycle as its input would still find its match
      if (s_axis_tvalid && s_axis_tready) begin
        decode_word(s_axis_tuser, s_axis_tdata, s_axis_tlast, w);
        decoded_q.push_back(w);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected output word: tdata %0h tuser %0b", m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          check_field("out_valid", 8'(want.emit), 8'(m_axis_tuser));
          check_field("out_byte", want.data, m_axis_tdata[7:0]);
          check_field("copy_pending", 8'(want.copy_pending), 8'(m_axis_tdata[8]));
          check_field("status", 8'(want.status), 8'(m_axis_tdata[10:9]));
        end
      end
      owed <= decoded_q.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // where the final word of the block falls, if anywhere
  typedef enum {
    END_NONE, END_TOKEN, END_LIT_EXT, END_LIT, END_OFF_LO, END_OFF_HI, END_MATCH_EXT,
    END_ZERO_OFF
  } cut_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  int          owed;
  int          mismatches;
  int          sent = 0;
  int          hist = 0;
  int          noise_pct = 30;
  logic        hold = 1'b0;
  logic        quiet;

  assign quiet = (sent >= 500) && (sent < 700);

  lz4_block_decoder DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  lz4_block_decoder_check decode_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .owed          (owed),
    .mismatches    (mismatches)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stalls, none in the quiet stretch, stalled throughout while held off
  initial begin
    forever begin
      @(posedge clk);
      m_tready <= !hold && (quiet || $urandom_range(99) >= 25);
    end
  end

  // long hold-off so the block fills up and stalls its input
  initial begin
    wait (sent >= 300);
    hold <= 1'b1;
    repeat (200) @(posedge clk);
    hold <= 1'b0;
  end

  task automatic send_word(input logic tick, input logic [7:0] b, input logic last);
    while (!quiet && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= tick;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // compressed byte, sometimes preceded by a tick that owes nothing
  task automatic parse_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < noise_pct) send_word(1'b1, 8'($urandom), 1'($urandom));
    send_word(1'b0, b, last);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
  endtask

  // one token/literals/offset/match group; off_req > 0 fixed, < 0 whole history, 0 random
  task automatic send_seq(input int lits, input int mlen, input int off_req, input cut_t cut);
    int         rem;
    int         ticks;
    int         avail;
    int         span;
    int         mid;
    logic [7:0] b;
    logic [3:0] lnib;
    logic [3:0] mnib;
    lnib = (lits >= 15) ? 4'd15 : 4'(lits);
    mnib = (mlen >= 19) ? 4'd15 : 4'(mlen - 4);
    parse_byte({lnib, mnib}, cut == END_TOKEN);
    if (cut == END_TOKEN) return;
    if (lits >= 15) begin
      rem = lits - 15;
      do begin
        b = (rem >= 255) ? 8'd255 : 8'(rem);
        rem -= b;
        parse_byte(b, cut == END_LIT_EXT);
        if (cut == END_LIT_EXT) return;
      end while (b == 8'd255);
    end
    mid = lits / 2;
    for (int i = 0; i < lits; i++) begin
      case ($urandom_range(9))
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      parse_byte(b, cut == END_LIT && i == mid);
      if (hist < 65536) hist++;
      if (cut == END_LIT && i == mid) return;
    end
    // never reach back past the first byte written
    avail = (hist > 65535) ? 65535 : hist;
    if (cut == END_ZERO_OFF) span = 0;
    else if (off_req > 0) span = off_req;
    else if (off_req < 0) span = avail;
    else if ($urandom_range(4) == 0) span = $urandom_range(avail, 1);
    else span = $urandom_range((avail < 16) ? avail : 16, 1);
    parse_byte(span[7:0], cut == END_OFF_LO);
    if (cut == END_OFF_LO) return;
    parse_byte(span[15:8], cut == END_OFF_HI || (cut == END_ZERO_OFF && $urandom_range(1) == 1));
    if (cut == END_ZERO_OFF) return;
    if (mnib == 4'd15 && cut != END_OFF_HI) begin
      rem = mlen - 19;
      ticks = 19;
      do begin
        b = (rem >= 255) ? 8'd255 : 8'(rem);
        rem -= b;
        ticks += b;
        parse_byte(b, cut == END_MATCH_EXT);
      end while (b == 8'd255 && cut != END_MATCH_EXT);
    end else begin
      ticks = mnib + 4;
    end
    for (int i = 0; i < ticks; i++) begin
      // stray compressed bytes during the copy are dropped by the block
      if ($urandom_range(99) < noise_pct) send_word(1'b0, 8'($urandom), 1'($urandom));
      send_word(1'b1, 8'($urandom), 1'($urandom));
      if (hist < 65536) hist++;
    end
  endtask

  initial begin
    int   lits;
    int   mlen;
    bit   paused;
    cut_t ending;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_seq(3, 4, 1, END_NONE);
    send_word(1'b1, 8'hFF, 1'b1);
    send_seq(0, 4, -1, END_NONE);
    send_seq(1, 5, -1, END_NONE);

    noise_pct = 8;
    while (sent < 1250) begin
      if (!paused && sent >= 800) begin
        drain_results();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 10)
        lits = 15 + (($urandom_range(3) == 0) ? $urandom_range(300, 255) : $urandom_range(40, 0));
      else
        lits = $urandom_range(14, 0);
      if ($urandom_range(99) < 10)
        mlen = 19 + (($urandom_range(9) == 0) ? $urandom_range(280, 255) : $urandom_range(30, 0));
      else
        mlen = $urandom_range(18, 4);
      send_seq(lits, mlen, 0, END_NONE);
    end

    ending = cut_t'($urandom_range(END_ZERO_OFF, END_TOKEN));
    lits = (ending == END_LIT_EXT) ? 15 + $urandom_range(300, 0) : $urandom_range(30, 1);
    mlen = (ending == END_MATCH_EXT) ? 19 + $urandom_range(300, 0) : $urandom_range(30, 4);
    send_seq(lits, mlen, 0, ending);
    // block has ended: everything from here on is ignored
    repeat (6) send_word(1'($urandom), 8'($urandom), 1'($urandom));

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/lz4bd_pkg.sv
sv/lz4bd_parser.sv
sv/lz4_block_decoder.sv
tb/sv/lz4_block_decoder_check.sv
tb/sv/tb_top.sv
